@@ hw/rtl/trdz_pkg.sv @@
// trdz_pkg: shared widths, stage map and sideband types for the thumbstick
// radial dead zone pipeline. Used by every module under hw/rtl.
`timescale 1ns / 1ps
package trdz_pkg;

  // Field widths
  localparam int IN_W     = 16;
  localparam int OUT_W    = 17;
  localparam int DZ_W     = 15;
  localparam int OUT_FRAC = 15;

  // Axis resolution actually used (8..16)
  localparam int AXIS_BITS = 16;
  localparam int MAG_W     = AXIS_BITS;
  localparam int SQ_W      = 2 * AXIS_BITS;
  localparam int DZ2_W     = 2 * DZ_W;
  localparam int ZC_W      = (SQ_W > DZ2_W) ? SQ_W : DZ2_W;
  localparam int N_W       = SQ_W + 16;
  localparam int RT_W      = AXIS_BITS + 8;
  localparam int REM_W     = RT_W + 3;
  localparam int GAIN_W    = RT_W;
  localparam int NUM_W     = MAG_W + GAIN_W;
  localparam int DEN_W     = AXIS_BITS + RT_W;
  localparam int QB        = OUT_W;
  localparam int DIV_W     = NUM_W + OUT_FRAC + 1;
  localparam int RW        = (DIV_W > DEN_W + QB) ? DIV_W : DEN_W + QB;
  localparam int WIDE_W    = 32 + RT_W;

  localparam logic [AXIS_BITS:0] FULL_SCALE = (AXIS_BITS + 1)'(1) << (AXIS_BITS - 1);

  localparam logic signed [OUT_W-1:0] OUT_MAX = 17'sh0FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 17'sh10000;

  // Stage map
  localparam int P_IN   = 0;
  localparam int P_SQ   = 1;
  localparam int P_SUM  = 2;
  localparam int P_RT   = 3;
  localparam int P_GAIN = P_RT + RT_W;
  localparam int P_MUL  = P_GAIN + 1;
  localparam int P_DIV  = P_MUL + 1;
  localparam int P_FIN  = P_DIV + QB + 1;
  localparam int NST    = P_FIN + 1;

  // Register indexes
  localparam logic REG_LEFT_DZ  = 1'b0;
  localparam logic REG_RIGHT_DZ = 1'b1;

  // Sideband through the root pipeline
  typedef struct packed {
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    logic             sx;
    logic             sy;
    logic [DZ_W-1:0]  dz;
    logic             zero;
  } sq_side_t;

  // Sideband through the divider pipeline
  typedef struct packed {
    logic sx;
    logic sy;
    logic zero;
  } dv_side_t;

endpackage

@@ hw/rtl/trdz_sqrt.sv @@
// trdz_sqrt: pipelined restoring integer square root, one result bit per stage.
// Depends on trdz_pkg.
`timescale 1ns / 1ps
module trdz_sqrt (
  input  logic                   clk,
  input  logic [trdz_pkg::RT_W-1:0] en,
  input  logic [trdz_pkg::N_W-1:0]  n_in,
  input  trdz_pkg::sq_side_t        side_in,
  output logic [trdz_pkg::RT_W-1:0] root_out,
  output trdz_pkg::sq_side_t        side_out
);
  import trdz_pkg::*;

  logic [REM_W-1:0] rem  [RT_W];
  logic [RT_W-1:0]  root [RT_W];
  logic [N_W-1:0]   nsh  [RT_W];
  sq_side_t         side [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_st
    logic [REM_W-1:0] rem_i;
    logic [RT_W-1:0]  root_i;
    logic [N_W-1:0]   n_i;
    sq_side_t         side_i;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign n_i    = n_in;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem[k-1];
      assign root_i = root[k-1];
      assign n_i    = nsh[k-1];
      assign side_i = side[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign r2    = {rem_i[REM_W-3:0], n_i[N_W-1 -: 2]};
    assign trial = {1'b0, root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (r2 >= trial) begin
          rem[k]  <= r2 - trial;
          root[k] <= {root_i[RT_W-2:0], 1'b1};
        end else begin
          rem[k]  <= r2;
          root[k] <= {root_i[RT_W-2:0], 1'b0};
        end
        nsh[k]  <= {n_i[N_W-3:0], 2'b00};
        side[k] <= side_i;
      end
    end
  end

  assign root_out = root[RT_W-1];
  assign side_out = side[RT_W-1];

endmodule

@@ hw/rtl/trdz_div.sv @@
// trdz_div: pipelined rounded division of two numerators by a shared divisor,
// with an early overflow flag. Depends on trdz_pkg.
`timescale 1ns / 1ps
module trdz_div (
  input  logic                      clk,
  input  logic [trdz_pkg::QB:0]        en,
  input  logic [trdz_pkg::NUM_W-1:0]   num_x,
  input  logic [trdz_pkg::NUM_W-1:0]   num_y,
  input  logic [trdz_pkg::DEN_W-1:0]   den_in,
  input  trdz_pkg::dv_side_t           side_in,
  output logic [trdz_pkg::QB-1:0]      q_x,
  output logic [trdz_pkg::QB-1:0]      q_y,
  output logic                         ovf_x,
  output logic                         ovf_y,
  output trdz_pkg::dv_side_t           side_out
);
  import trdz_pkg::*;

  logic [RW-1:0]    rx   [QB+1];
  logic [RW-1:0]    ry   [QB+1];
  logic [QB-1:0]    qx   [QB+1];
  logic [QB-1:0]    qy   [QB+1];
  logic [DEN_W-1:0] den  [QB+1];
  logic             ox   [QB+1];
  logic             oy   [QB+1];
  dv_side_t         side [QB+1];

  // stage 0: scale, add half divisor, flag quotients of 2^QB or more
  logic [RW-1:0] nx0, ny0, dlim;
  assign nx0  = (RW'(num_x) << OUT_FRAC) + (RW'(den_in) >> 1);
  assign ny0  = (RW'(num_y) << OUT_FRAC) + (RW'(den_in) >> 1);
  assign dlim = RW'(den_in) << QB;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rx[0]   <= nx0;
      ry[0]   <= ny0;
      qx[0]   <= '0;
      qy[0]   <= '0;
      den[0]  <= den_in;
      ox[0]   <= (nx0 >= dlim);
      oy[0]   <= (ny0 >= dlim);
      side[0] <= side_in;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar j = 1; j <= QB; j++) begin : g_st
    logic [RW-1:0] dsh;
    assign dsh = RW'(den[j-1]) << (QB - j);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        if (rx[j-1] >= dsh) begin
          rx[j] <= rx[j-1] - dsh;
          qx[j] <= qx[j-1] | (QB'(1) << (QB - j));
        end else begin
          rx[j] <= rx[j-1];
          qx[j] <= qx[j-1];
        end
        if (ry[j-1] >= dsh) begin
          ry[j] <= ry[j-1] - dsh;
          qy[j] <= qy[j-1] | (QB'(1) << (QB - j));
        end else begin
          ry[j] <= ry[j-1];
          qy[j] <= qy[j-1];
        end
        den[j]  <= den[j-1];
        ox[j]   <= ox[j-1];
        oy[j]   <= oy[j-1];
        side[j] <= side[j-1];
      end
    end
  end

  assign q_x      = qx[QB];
  assign q_y      = qy[QB];
  assign ovf_x    = ox[QB];
  assign ovf_y    = oy[QB];
  assign side_out = side[QB];

endmodule

@@ hw/rtl/trdz_stick.sv @@
// trdz_stick: full datapath for one stick: squares, dead-zone test, root,
// gain and divisor products, division and output saturation.
// Depends on trdz_pkg, trdz_sqrt, trdz_div.
`timescale 1ns / 1ps
module trdz_stick (
  input  logic                            clk,
  input  logic [trdz_pkg::NST-1:0]        en,
  input  logic signed [trdz_pkg::IN_W-1:0]  raw_x,
  input  logic signed [trdz_pkg::IN_W-1:0]  raw_y,
  input  logic [trdz_pkg::DZ_W-1:0]         dz,
  output logic signed [trdz_pkg::OUT_W-1:0] out_x,
  output logic signed [trdz_pkg::OUT_W-1:0] out_y
);
  import trdz_pkg::*;

  // input stage
  logic [AXIS_BITS-1:0] s0_rx, s0_ry;
  logic [DZ_W-1:0]      s0_dz;
  always_ff @(posedge clk) begin
    if (en[P_IN]) begin
      s0_rx <= raw_x[AXIS_BITS-1:0];
      s0_ry <= raw_y[AXIS_BITS-1:0];
      s0_dz <= dz;
    end
  end

  // magnitudes and signs; Y is negated
  logic [MAG_W-1:0] mag_x, mag_y;
  logic             neg_x, neg_y;
  assign mag_x = s0_rx[AXIS_BITS-1] ? (~s0_rx + 1'b1) : s0_rx;
  assign mag_y = s0_ry[AXIS_BITS-1] ? (~s0_ry + 1'b1) : s0_ry;
  assign neg_x = s0_rx[AXIS_BITS-1];
  assign neg_y = (s0_ry != '0) && !s0_ry[AXIS_BITS-1];

  // squares
  logic [MAG_W-1:0] s1_mx, s1_my;
  logic             s1_sx, s1_sy, s1_big;
  logic [DZ_W-1:0]  s1_dz;
  logic [SQ_W-1:0]  s1_qx, s1_qy;
  logic [DZ2_W-1:0] s1_dz2;
  always_ff @(posedge clk) begin
    if (en[P_SQ]) begin
      s1_mx  <= mag_x;
      s1_my  <= mag_y;
      s1_sx  <= neg_x;
      s1_sy  <= neg_y;
      s1_dz  <= s0_dz;
      s1_qx  <= mag_x * mag_x;
      s1_qy  <= mag_y * mag_y;
      s1_dz2 <= s0_dz * s0_dz;
      s1_big <= ((AXIS_BITS + 1 > DZ_W ? AXIS_BITS + 1 : DZ_W + 1)'(s0_dz) >=
                 (AXIS_BITS + 1 > DZ_W ? AXIS_BITS + 1 : DZ_W + 1)'(FULL_SCALE));
    end
  end

  // length squared and dead-zone test
  logic [SQ_W-1:0] s2_s;
  sq_side_t        s2_side;
  logic [SQ_W-1:0] ssum;
  assign ssum = s1_qx + s1_qy;
  always_ff @(posedge clk) begin
    if (en[P_SUM]) begin
      s2_s         <= ssum;
      s2_side.mx   <= s1_mx;
      s2_side.my   <= s1_my;
      s2_side.sx   <= s1_sx;
      s2_side.sy   <= s1_sy;
      s2_side.dz   <= s1_dz;
      s2_side.zero <= s1_big || (ZC_W'(ssum) <= ZC_W'(s1_dz2));
    end
  end

  // length with 8 fraction bits
  logic [RT_W-1:0] rt_len;
  sq_side_t        rt_side;
  trdz_sqrt u_sqrt (
    .clk      (clk),
    .en       (en[P_RT +: RT_W]),
    .n_in     ({s2_s, 16'b0}),
    .side_in  (s2_side),
    .root_out (rt_len),
    .side_out (rt_side)
  );

  // gain = len - dz, and full scale minus dz
  logic [GAIN_W-1:0]    g_gain, g_len;
  logic [AXIS_BITS-1:0] g_fsdz;
  logic [MAG_W-1:0]     g_mx, g_my;
  dv_side_t             g_side;
  logic [WIDE_W-1:0]    gain_w;
  logic [AXIS_BITS:0]   fsdz_w;
  assign gain_w = WIDE_W'(rt_len) - (WIDE_W'(rt_side.dz) << 8);
  assign fsdz_w = FULL_SCALE - (AXIS_BITS + 1)'(rt_side.dz);
  always_ff @(posedge clk) begin
    if (en[P_GAIN]) begin
      g_gain      <= gain_w[GAIN_W-1:0];
      g_len       <= rt_len;
      g_fsdz      <= fsdz_w[AXIS_BITS-1:0];
      g_mx        <= rt_side.mx;
      g_my        <= rt_side.my;
      g_side.sx   <= rt_side.sx;
      g_side.sy   <= rt_side.sy;
      g_side.zero <= rt_side.zero;
    end
  end

  // numerator and divisor products
  logic [NUM_W-1:0] m_nx, m_ny;
  logic [DEN_W-1:0] m_den;
  dv_side_t         m_side;
  always_ff @(posedge clk) begin
    if (en[P_MUL]) begin
      m_nx   <= g_mx * g_gain;
      m_ny   <= g_my * g_gain;
      m_den  <= g_fsdz * g_len;
      m_side <= g_side;
    end
  end

  logic [QB-1:0] d_qx, d_qy;
  logic          d_ox, d_oy;
  dv_side_t      d_side;
  trdz_div u_div (
    .clk      (clk),
    .en       (en[P_DIV +: QB + 1]),
    .num_x    (m_nx),
    .num_y    (m_ny),
    .den_in   (m_den),
    .side_in  (m_side),
    .q_x      (d_qx),
    .q_y      (d_qy),
    .ovf_x    (d_ox),
    .ovf_y    (d_oy),
    .side_out (d_side)
  );

  // sign, saturate, zero in the dead zone
  function automatic logic signed [OUT_W-1:0] finish(
    input logic [QB-1:0] q, input logic ovf, input logic neg, input logic zero
  );
    logic signed [OUT_W-1:0] r;
    if (zero) begin
      r = '0;
    end else if (neg) begin
      if (ovf || q > QB'(17'h10000)) r = OUT_MIN;
      else r = ~q + 1'b1;
    end else begin
      if (ovf || q > QB'(OUT_MAX)) r = OUT_MAX;
      else r = q;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en[P_FIN]) begin
      out_x <= finish(d_qx, d_ox, d_side.sx, d_side.zero);
      out_y <= finish(d_qy, d_oy, d_side.sy, d_side.zero);
    end
  end

endmodule

@@ hw/rtl/thumbstick_radial_dead_zone.sv @@
// thumbstick_radial_dead_zone: top level, APB dead-zone registers, pipeline
// valid/enable chain and the two stick datapaths. Depends on trdz_pkg, trdz_stick.
`timescale 1ns / 1ps
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | left_raw_x/y, right_raw_x/y (s16)
//  output   | out_valid / out_ready| left_out_x/y, right_out_x/y (s17, Q15)
//  config   | psel/penable/pready  | paddr[2:0], pwdata, prdata (32 bit)
//
//  One sample per cycle while the output is not stalled; the pipeline holds
//  the 24-stage root pipeline and the 18-stage divider pipeline.
//  Each stage holds its beat until the next stage frees, so bubbles close up
//  under an output stall and nothing is dropped or repeated.
//  Synchronous reset clears the stage valid bits and loads the default radii.
module thumbstick_radial_dead_zone (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [trdz_pkg::IN_W-1:0]  left_raw_x,
  input  logic signed [trdz_pkg::IN_W-1:0]  left_raw_y,
  input  logic signed [trdz_pkg::IN_W-1:0]  right_raw_x,
  input  logic signed [trdz_pkg::IN_W-1:0]  right_raw_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [trdz_pkg::OUT_W-1:0] left_out_x,
  output logic signed [trdz_pkg::OUT_W-1:0] left_out_y,
  output logic signed [trdz_pkg::OUT_W-1:0] right_out_x,
  output logic signed [trdz_pkg::OUT_W-1:0] right_out_y
);
  import trdz_pkg::*;

  // config registers
  logic [DZ_W-1:0] left_dz, right_dz;
  logic            wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= DZ_W'(7849);
      right_dz <= DZ_W'(8689);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_LEFT_DZ:  left_dz  <= pwdata[DZ_W-1:0];
        REG_RIGHT_DZ: right_dz <= pwdata[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LEFT_DZ:  prdata = 32'(left_dz);
      REG_RIGHT_DZ: prdata = 32'(right_dz);
      default:      prdata = '0;
    endcase
  end

  // stage valids and per-stage advance
  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  trdz_stick u_left (
    .clk   (clk),
    .en    (en),
    .raw_x (left_raw_x),
    .raw_y (left_raw_y),
    .dz    (left_dz),
    .out_x (left_out_x),
    .out_y (left_out_y)
  );

  trdz_stick u_right (
    .clk   (clk),
    .en    (en),
    .raw_x (right_raw_x),
    .raw_y (right_raw_y),
    .dz    (right_dz),
    .out_x (right_out_x),
    .out_y (right_out_y)
  );

  // checks
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted beat not in first stage");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[NST-1] |-> in_ready)
    else $error("input blocked with empty output stage");

  a_cfg_left: assert property (@(posedge clk) disable iff (rst)
    wr_en && paddr[2] == REG_LEFT_DZ |=> left_dz == $past(pwdata[DZ_W-1:0]))
    else $error("left dead zone write lost");

endmodule

@@ verif/tb.sv @@
// tb: self-checking bench for thumbstick_radial_dead_zone with a rounding
// scale predictor and a result scoreboard. Depends on trdz_pkg and the DUT.
`timescale 1ns / 1ps

module tb;
  import trdz_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 3 * NST;

  typedef struct packed {
    logic signed [OUT_W-1:0] lx;
    logic signed [OUT_W-1:0] ly;
    logic signed [OUT_W-1:0] rx;
    logic signed [OUT_W-1:0] ry;
  } sticks_t;

  // Scoreboard: holds the conditioned axes expected per accepted sample
  class stick_scoreboard;
    sticks_t pending[$];
    int unsigned mismatches;
    int unsigned checked;

    function void note_sample(sticks_t exp_axes);
      pending.push_back(exp_axes);
    endfunction

    function void check_result(sticks_t got);
      sticks_t exp_axes;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %h", got);
        return;
      end
      exp_axes = pending.pop_front();
      checked++;
      if (exp_axes != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat %0d: exp %0d %0d %0d %0d got %0d %0d %0d %0d", checked,
                   exp_axes.lx, exp_axes.ly, exp_axes.rx, exp_axes.ry,
                   got.lx, got.ly, got.rx, got.ry);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IN_W-1:0] left_raw_x = '0, left_raw_y = '0, right_raw_x = '0, right_raw_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] left_out_x, left_out_y, right_out_x, right_out_y;

  thumbstick_radial_dead_zone dut (.*);

  stick_scoreboard sb = new();
  logic [DZ_W-1:0] left_dz_model = 15'd7849;
  logic [DZ_W-1:0] right_dz_model = 15'd8689;
  bit calm = 1'b0;        // no idling in the closing stretch
  bit hold_off = 1'b0;    // long receiver stall request
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Integer square root, bit by bit
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Scale one axis, round half away from zero, saturate to 17 bits
  function automatic logic signed [OUT_W-1:0] scaled_axis(longint v, longint unsigned gain,
                                                          longint unsigned den);
    longint unsigned mag, q;
    mag = (v < 0) ? -v : v;
    q = (mag * gain * (64'd1 << OUT_FRAC) + den / 2) / den;
    if (v < 0) return (q > 65536) ? OUT_MIN : OUT_W'(-longint'(q));
    return (q > 65535) ? OUT_MAX : OUT_W'(q);
  endfunction

  function automatic void conditioned_stick(logic signed [IN_W-1:0] rx, logic signed [IN_W-1:0] ry,
                                            logic [DZ_W-1:0] dz,
                                            output logic signed [OUT_W-1:0] ox,
                                            output logic signed [OUT_W-1:0] oy);
    longint x, y;
    longint unsigned s, len8, gain, den, fs, dzl;
    x = rx;
    y = -longint'(ry);
    fs = 64'd1 << (AXIS_BITS - 1);
    dzl = dz;
    ox = '0;
    oy = '0;
    if (dzl >= fs) return;
    s = x * x + y * y;
    if (s <= dzl * dzl) return;
    len8 = root_floor(s << 16);
    gain = len8 - (dzl << 8);
    den = (fs - dzl) * len8;
    ox = scaled_axis(x, gain, den);
    oy = scaled_axis(y, gain, den);
  endfunction

  // APB register write: setup then access
  task automatic write_dead_zone(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx[0], 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx[0] == REG_LEFT_DZ) left_dz_model = val[DZ_W-1:0];
    else right_dz_model = val[DZ_W-1:0];
  endtask

  task automatic random_gap();
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one sample beat and wait for it to be taken
  task automatic send_sample(logic signed [IN_W-1:0] lx, logic signed [IN_W-1:0] ly,
                             logic signed [IN_W-1:0] rx, logic signed [IN_W-1:0] ry);
    sticks_t e;
    random_gap();
    in_valid <= 1'b1;
    left_raw_x <= lx; left_raw_y <= ly; right_raw_x <= rx; right_raw_y <= ry;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    conditioned_stick(lx, ly, left_dz_model, e.lx, e.ly);
    conditioned_stick(rx, ry, right_dz_model, e.rx, e.ry);
    sb.note_sample(e);
    sent++;
  endtask

  // Random stick position: mostly radial-ish, some near the dead zone, some corners
  function automatic logic signed [IN_W-1:0] random_axis();
    case ($urandom_range(0, 4))
      0: return IN_W'($urandom_range(0, 16'hFFFF));
      1: return IN_W'($signed($urandom_range(0, 20000)) - 10000);
      2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (NST) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    repeat (count)
      send_sample(random_axis(), random_axis(), random_axis(), random_axis());
  endtask

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        n = 0;
        while (n < 200) begin
          @(posedge clk);
          n++;
        end
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Output monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result({left_out_x, left_out_y, right_out_x, right_out_y});
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset radii, extremes, dead-zone edge, corners
    send_sample(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    send_sample(16'sd7849, 16'sd0, 16'sd8689, 16'sd0);
    send_sample(16'sd7850, 16'sd0, 16'sd0, -16'sd8690);
    send_sample(16'sh8000, 16'sh0000, 16'sh0000, 16'sh7FFF);
    send_sample(16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh0001);
    wait_drained();

    // Dead zone zero: every nonzero position passes
    write_dead_zone(REG_LEFT_DZ, 32'd0);
    write_dead_zone(REG_RIGHT_DZ, 32'd0);
    send_sample(16'sd1, 16'sd0, 16'sd0, -16'sd1);
    send_sample(16'sd0, 16'sd0, 16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh8000, 16'sd3, 16'sd4);
    random_phase(300);
    wait_drained();

    // Largest radius, just under full scale: only positions beyond it pass; upper bits ignored
    write_dead_zone(REG_LEFT_DZ, 32'hFFFF_FFFF);
    write_dead_zone(REG_RIGHT_DZ, 32'd32767);
    send_sample(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    random_phase(200);
    wait_drained();

    // Tiny and mid radii, then pressure: receiver holds off while samples keep coming
    write_dead_zone(REG_LEFT_DZ, 32'd1);
    write_dead_zone(REG_RIGHT_DZ, 32'd20000);
    hold_off = 1'b1;
    random_phase(400);
    wait_drained();

    write_dead_zone(REG_LEFT_DZ, $urandom_range(0, 32767));
    write_dead_zone(REG_RIGHT_DZ, $urandom_range(0, 32767));
    random_phase(600);
    wait_drained();

    write_dead_zone(REG_LEFT_DZ, 32'd7849);
    write_dead_zone(REG_RIGHT_DZ, 32'd8689);
    random_phase(150);
    calm = 1'b1;
    random_phase(280);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples, %0d checked, over six dead-zone settings", sent, sb.checked);
    $display("including zero and full-scale radii and a long output stall");
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

@@ thumbstick_radial_dead_zone.f @@
hw/rtl/trdz_pkg.sv
hw/rtl/trdz_sqrt.sv
hw/rtl/trdz_div.sv
hw/rtl/trdz_stick.sv
hw/rtl/thumbstick_radial_dead_zone.sv
verif/tb.sv
